[rtl/core/stc_pkg.sv]
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants for the sample timestamp to calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

  // Register indexes, taken from paddr[2].
  localparam logic REG_RATE = 1'b0;
  localparam logic REG_BASE = 1'b1;

  localparam logic [14:0] RATE_RESET   = 15'd100;
  localparam logic [15:0] BASE_RESET   = 16'd17532;
  localparam logic [19:0] PERIOD_RESET = 20'd10000;
  localparam logic [19:0] US_PER_SEC   = 20'd1000000;
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;

  // Reciprocals for division by constants; each estimate is low by at most one.
  localparam logic [25:0] RCP_125   = 26'd34359738;    // 2^32 / 125
  localparam logic [31:0] RCP_15625 = 32'd2251799813;  // 2^45 / 15625
  localparam logic [27:0] RCP_675   = 28'd203613264;   // 2^37 / 675
  localparam logic [19:0] RCP_25    = 20'd671088;      // 2^24 / 25
  localparam logic [12:0] RCP_225   = 13'd4660;        // 2^20 / 225
  localparam logic [8:0]  RCP_15    = 9'd273;          // 2^12 / 15
  localparam logic [15:0] RCP_1461  = 16'd45933;       // 2^26 / 1461

  localparam logic [18:0] DAYS_1601_TO_1970 = 19'd134774;
  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [10:0] DAYS_4Y   = 11'd1461;
  localparam logic [8:0]  DAYS_1Y   = 9'd365;

  typedef struct packed {
    logic [19:0] period;
    logic [15:0] base_days;
  } cfg_t;

  typedef struct packed {
    logic [33:0] abs_sec;
    logic [19:0] frac;
  } ofs_t;

  typedef struct packed {
    logic [17:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [13:0] tenth;
  } tod_t;

endpackage

`default_nettype wire

[rtl/core/sample_timestamp_to_calendar.sv]
// ----------------------------------------------------------------------------
// sample_timestamp_to_calendar
// Calendar time of one sample in a packet from its start time and index.
// ----------------------------------------------------------------------------
// One beat per cycle unless m_tready or a running rate divide holds the flow.
// The 15-stage pipeline stalls without loss.
// A sample_rate write runs a serial divider; s_tready is low while it runs.
// Reset (rst, synchronous) empties the pipeline and loads sample_rate 100,
// epoch_base_days 17532 and a 10000 us sample period.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_timestamp_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // seconds_after_base[31:0], start_nanoseconds[61:32], sample_index[77:62]
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // year[11:0], day_of_year[20:12], hour[25:21], minute[31:26],
  // second[37:32], tenth_millisecond[51:38]
  output logic [55:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  stc_pkg::cfg_t cfg;
  stc_pkg::ofs_t ofs;
  stc_pkg::tod_t tod_mid, tod_out;
  logic          busy;
  logic          ofs_in_ready;
  logic          ofs_valid, ofs_ready;
  logic          tod_valid, tod_ready;
  logic [11:0]   year;
  logic [8:0]    day_of_year;

  assign pready = 1'b1;

  stc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .cfg, .busy
  );

  // Hold off new beats while the sample period is being recomputed.
  assign s_tready = ofs_in_ready && !busy;

  stc_ofs u_ofs (
    .clk, .rst,
    .in_valid  (s_tvalid && !busy),
    .in_ready  (ofs_in_ready),
    .secs      (s_tdata[31:0]),
    .ns        (s_tdata[61:32]),
    .idx       (s_tdata[77:62]),
    .cfg,
    .out_valid (ofs_valid),
    .out_ready (ofs_ready),
    .out       (ofs)
  );

  stc_tod u_tod (
    .clk, .rst,
    .in_valid  (ofs_valid),
    .in_ready  (ofs_ready),
    .in        (ofs),
    .out_valid (tod_valid),
    .out_ready (tod_ready),
    .out       (tod_mid)
  );

  stc_civ u_civ (
    .clk, .rst,
    .in_valid    (tod_valid),
    .in_ready    (tod_ready),
    .in          (tod_mid),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .year,
    .day_of_year,
    .tod         (tod_out)
  );

  assign m_tdata = {4'd0, tod_out.tenth, tod_out.second, tod_out.minute,
                    tod_out.hour, day_of_year, year};

endmodule

`default_nettype wire

[rtl/core/stc_cfg.sv]
// ----------------------------------------------------------------------------
// stc_cfg
// Register file and serial divider that derives the sample period.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_cfg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output stc_pkg::cfg_t     cfg,
  output logic              busy
);

  logic [14:0] sample_rate;
  logic [15:0] base_days;
  logic [19:0] period;
  logic [14:0] divisor;
  logic [14:0] rem;
  logic [19:0] dvd;
  logic [4:0]  count;
  logic        wr;
  logic [15:0] trial;
  logic        ge;
  logic [14:0] rem_next;

  assign wr = psel & penable & pwrite;

  // Readback of the two registers.
  assign prdata = (paddr[2] == stc_pkg::REG_BASE) ? {16'd0, base_days}
                                                  : {17'd0, sample_rate};

  // One restoring step: a quotient bit per cycle while busy.
  assign trial    = {rem, dvd[19]};
  assign ge       = trial >= {1'b0, divisor};
  assign rem_next = ge ? 15'(trial - {1'b0, divisor}) : trial[14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= stc_pkg::RATE_RESET;
      base_days   <= stc_pkg::BASE_RESET;
      period      <= stc_pkg::PERIOD_RESET;
      busy        <= 1'b0;
      count       <= 5'd0;
    end else if (wr && paddr[2] == stc_pkg::REG_RATE) begin
      sample_rate <= pwdata[14:0];
      busy        <= 1'b1;
      count       <= 5'd0;
    end else begin
      if (wr && paddr[2] == stc_pkg::REG_BASE) begin
        base_days <= pwdata[15:0];
      end
      if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd19) begin
          busy   <= 1'b0;
          period <= {dvd[18:0], ge};
        end
      end
    end
  end

  // Divider datapath; a rate of zero divides by one.
  always_ff @(posedge clk) begin
    if (wr && paddr[2] == stc_pkg::REG_RATE) begin
      divisor <= (pwdata[14:0] == 15'd0) ? 15'd1 : pwdata[14:0];
      rem     <= 15'd0;
      dvd     <= stc_pkg::US_PER_SEC;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[18:0], ge};
    end
  end

  assign cfg.period    = period;
  assign cfg.base_days = base_days;

endmodule

`default_nettype wire

[rtl/core/stc_ofs.sv]
// ----------------------------------------------------------------------------
// stc_ofs
// Five-stage pipeline: sample offset in microseconds, carry into seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_ofs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [31:0]   secs,
  input  wire logic [29:0]   ns,
  input  wire logic [15:0]   idx,
  input  wire stc_pkg::cfg_t cfg,
  output logic               out_valid,
  input  wire logic          out_ready,
  output stc_pkg::ofs_t      out
);

  logic va, vb, vc, vd, ve;
  logic ena, enb, enc, end_s, ene;

  logic [26:0] x_a;
  logic [52:0] qp_a;
  logic [35:0] ip_a;
  logic [33:0] bs_a, bs_b, bs_c, bs_d;
  logic [36:0] us_b, us_c, us_d;
  logic [62:0] cp_c;
  logic [17:0] c1_d;
  logic [37:0] m_d;

  logic [20:0] q1;
  logic [26:0] r1;
  logic [20:0] q;
  logic [17:0] c1;
  logic [37:0] f0;
  logic        fge;
  logic [17:0] carry;
  logic [19:0] frac;

  // Each stage moves when it is empty or the next one moves.
  assign ene      = !ve || out_ready;
  assign end_s    = !vd || ene;
  assign enc      = !vc || end_s;
  assign enb      = !vb || enc;
  assign ena      = !va || enb;
  assign in_ready = ena;

  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve} <= 5'd0;
    end else begin
      if (ena)   va <= in_valid;
      if (enb)   vb <= va;
      if (enc)   vc <= vb;
      if (end_s) vd <= vc;
      if (ene)   ve <= vd;
    end
  end

  // Stage A: nanoseconds over 1000 by reciprocal, sample offset product.
  always_ff @(posedge clk) begin
    if (ena) begin
      x_a  <= ns[29:3];
      qp_a <= 53'(ns[29:3]) * 53'(stc_pkg::RCP_125);
      ip_a <= 36'(idx) * 36'(cfg.period);
      bs_a <= 34'(cfg.base_days) * 34'(stc_pkg::SEC_PER_DAY) + 34'(secs);
    end
  end

  // Stage B: correct the quotient and form the microsecond sum.
  assign q1 = qp_a[52:32];
  assign r1 = x_a - 27'(28'(q1) * 28'd125);
  assign q  = q1 + 21'(r1 >= 27'd125);

  always_ff @(posedge clk) begin
    if (enb) begin
      us_b <= 37'(q) + 37'(ip_a);
      bs_b <= bs_a;
    end
  end

  // Stage C: microseconds over one million by reciprocal.
  always_ff @(posedge clk) begin
    if (enc) begin
      cp_c <= 63'(us_b[36:6]) * 63'(stc_pkg::RCP_15625);
      us_c <= us_b;
      bs_c <= bs_b;
    end
  end

  // Stage D: back-multiply the carry estimate.
  assign c1 = cp_c[62:45];

  always_ff @(posedge clk) begin
    if (end_s) begin
      c1_d <= c1;
      m_d  <= 38'(c1) * 38'(stc_pkg::US_PER_SEC);
      us_d <= us_c;
      bs_d <= bs_c;
    end
  end

  // Stage E: correct carry and fraction, add the carry into the seconds.
  assign f0    = 38'(us_d) - m_d;
  assign fge   = f0 >= 38'(stc_pkg::US_PER_SEC);
  assign carry = c1_d + 18'(fge);
  assign frac  = fge ? 20'(f0 - 38'(stc_pkg::US_PER_SEC)) : f0[19:0];

  always_ff @(posedge clk) begin
    if (ene) begin
      out.abs_sec <= bs_d + 34'(carry);
      out.frac    <= frac;
    end
  end

  assign out_valid = ve;

endmodule

`default_nettype wire

[rtl/core/stc_tod.sv]
// ----------------------------------------------------------------------------
// stc_tod
// Five-stage pipeline: day number, time of day and 100 us fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_tod (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire stc_pkg::ofs_t in,
  output logic               out_valid,
  input  wire logic          out_ready,
  output stc_pkg::tod_t      out
);

  logic va, vb, vc, vd, ve;
  logic ena, enb, enc, end_s, ene;

  logic [33:0] abs_a, abs_b;
  logic [54:0] dp_a;
  logic [37:0] tp_a;
  logic [19:0] frac_a;
  logic [17:0] days_b, days_c, days_d;
  logic [34:0] dm_b;
  logic [13:0] tenth_b, tenth_c, tenth_d;
  logic [16:0] sod_c, sod_d;
  logic [25:0] hp_d;

  logic [17:0] d1;
  logic [13:0] t1;
  logic [19:0] tr;
  logic [17:0] s0;
  logic        sge;
  logic [4:0]  h1;
  logic [16:0] hr0;
  logic        hge;
  logic [4:0]  hour;
  logic [11:0] hr;
  logic [18:0] mp;
  logic [5:0]  m1;
  logic [11:0] mr0;
  logic        mge;
  logic [5:0]  sec;

  assign ene      = !ve || out_ready;
  assign end_s    = !vd || ene;
  assign enc      = !vc || end_s;
  assign enb      = !vb || enc;
  assign ena      = !va || enb;
  assign in_ready = ena;

  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve} <= 5'd0;
    end else begin
      if (ena)   va <= in_valid;
      if (enb)   vb <= va;
      if (enc)   vc <= vb;
      if (end_s) vd <= vc;
      if (ene)   ve <= vd;
    end
  end

  // Stage A: day estimate and fraction estimate by reciprocal.
  always_ff @(posedge clk) begin
    if (ena) begin
      dp_a   <= 55'(in.abs_sec[33:7]) * 55'(stc_pkg::RCP_675);
      tp_a   <= 38'(in.frac[19:2]) * 38'(stc_pkg::RCP_25);
      abs_a  <= in.abs_sec;
      frac_a <= in.frac;
    end
  end

  // Stage B: back-multiply the day estimate, finish the fraction.
  assign d1 = dp_a[54:37];
  assign t1 = tp_a[37:24];
  assign tr = frac_a - 20'(21'(t1) * 21'd100);

  always_ff @(posedge clk) begin
    if (enb) begin
      days_b  <= d1;
      dm_b    <= 35'(d1) * 35'(stc_pkg::SEC_PER_DAY);
      abs_b   <= abs_a;
      tenth_b <= t1 + 14'(tr >= 20'd100);
    end
  end

  // Stage C: correct the day count, second of day.
  assign s0  = 18'(35'(abs_b) - dm_b);
  assign sge = s0 >= 18'(stc_pkg::SEC_PER_DAY);

  always_ff @(posedge clk) begin
    if (enc) begin
      days_c  <= days_b + 18'(sge);
      sod_c   <= sge ? 17'(s0 - 18'(stc_pkg::SEC_PER_DAY)) : s0[16:0];
      tenth_c <= tenth_b;
    end
  end

  // Stage D: hour estimate.
  always_ff @(posedge clk) begin
    if (end_s) begin
      hp_d    <= 26'(sod_c[16:4]) * 26'(stc_pkg::RCP_225);
      sod_d   <= sod_c;
      days_d  <= days_c;
      tenth_d <= tenth_c;
    end
  end

  // Stage E: correct hour, then minute and second of the remainder.
  assign h1   = hp_d[24:20];
  assign hr0  = sod_d - 17'(h1 * 17'd3600);
  assign hge  = hr0 >= 17'd3600;
  assign hour = h1 + 5'(hge);
  assign hr   = hge ? 12'(hr0 - 17'd3600) : hr0[11:0];
  assign mp   = 19'(hr[11:2]) * 19'(stc_pkg::RCP_15);
  assign m1   = mp[17:12];
  assign mr0  = hr - 12'(m1 * 12'd60);
  assign mge  = mr0 >= 12'd60;
  assign sec  = mge ? 6'(mr0 - 12'd60) : mr0[5:0];

  always_ff @(posedge clk) begin
    if (ene) begin
      out.days   <= days_d;
      out.hour   <= hour;
      out.minute <= m1 + 6'(mge);
      out.second <= sec;
      out.tenth  <= tenth_d;
    end
  end

  assign out_valid = ve;

endmodule

`default_nettype wire

[rtl/core/stc_civ.sv]
// ----------------------------------------------------------------------------
// stc_civ
// Five-stage pipeline: day number to Gregorian year and day of year.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_civ (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire stc_pkg::tod_t in,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [11:0]        year,
  output logic [8:0]         day_of_year,
  output stc_pkg::tod_t      tod
);

  logic va, vb, vc, vd, ve;
  logic ena, enb, enc, end_s, ene;

  logic [1:0]  n400_a, n400_b, n400_c, n400_d;
  logic [17:0] d_a;
  logic [1:0]  n100_b, n100_c, n100_d;
  logic [15:0] d_b, d_c;
  logic [31:0] p_c;
  logic [4:0]  n4_d;
  logic [10:0] d_d;
  stc_pkg::tod_t t_a, t_b, t_c, t_d;

  logic [18:0] d0;
  logic [1:0]  n400;
  logic [17:0] d4;
  logic [1:0]  n100;
  logic [4:0]  n4e;
  logic [15:0] r4;
  logic        r4ge;
  logic [1:0]  n1;
  logic [10:0] d1;

  assign ene      = !ve || out_ready;
  assign end_s    = !vd || ene;
  assign enc      = !vc || end_s;
  assign enb      = !vb || enc;
  assign ena      = !va || enb;
  assign in_ready = ena;

  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve} <= 5'd0;
    end else begin
      if (ena)   va <= in_valid;
      if (enb)   vb <= va;
      if (enc)   vc <= vb;
      if (end_s) vd <= vc;
      if (ene)   ve <= vd;
    end
  end

  // Stage A: shift to 1601 and split off whole 400-year cycles.
  assign d0 = 19'(in.days) + stc_pkg::DAYS_1601_TO_1970;

  always_comb begin
    if (d0 >= 19'(2 * stc_pkg::DAYS_400Y)) begin
      n400 = 2'd2;
      d4   = 18'(d0 - 19'(2 * stc_pkg::DAYS_400Y));
    end else if (d0 >= 19'(stc_pkg::DAYS_400Y)) begin
      n400 = 2'd1;
      d4   = 18'(d0 - 19'(stc_pkg::DAYS_400Y));
    end else begin
      n400 = 2'd0;
      d4   = d0[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      n400_a <= n400;
      d_a    <= d4;
      t_a    <= in;
    end
  end

  // Stage B: centuries, the last day of a 400-year cycle stays in the fourth.
  always_comb begin
    if (d_a >= 18'(3 * stc_pkg::DAYS_100Y)) begin
      n100 = 2'd3;
    end else if (d_a >= 18'(2 * stc_pkg::DAYS_100Y)) begin
      n100 = 2'd2;
    end else if (d_a >= 18'(stc_pkg::DAYS_100Y)) begin
      n100 = 2'd1;
    end else begin
      n100 = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (enb) begin
      n400_b <= n400_a;
      n100_b <= n100;
      d_b    <= 16'(d_a - 18'(n100) * 18'(stc_pkg::DAYS_100Y));
      t_b    <= t_a;
    end
  end

  // Stage C: four-year estimate by reciprocal.
  always_ff @(posedge clk) begin
    if (enc) begin
      p_c    <= 32'(d_b) * 32'(stc_pkg::RCP_1461);
      d_c    <= d_b;
      n400_c <= n400_b;
      n100_c <= n100_b;
      t_c    <= t_b;
    end
  end

  // Stage D: correct the four-year count.
  assign n4e  = p_c[30:26];
  assign r4   = d_c - 16'(n4e * 16'(stc_pkg::DAYS_4Y));
  assign r4ge = r4 >= 16'(stc_pkg::DAYS_4Y);

  always_ff @(posedge clk) begin
    if (end_s) begin
      n4_d   <= n4e + 5'(r4ge);
      d_d    <= r4ge ? 11'(r4 - 16'(stc_pkg::DAYS_4Y)) : r4[10:0];
      n400_d <= n400_c;
      n100_d <= n100_c;
      t_d    <= t_c;
    end
  end

  // Stage E: single years, the leap day at the end stays in the fourth year.
  always_comb begin
    if (d_d >= 11'(3 * stc_pkg::DAYS_1Y)) begin
      n1 = 2'd3;
    end else if (d_d >= 11'(2 * stc_pkg::DAYS_1Y)) begin
      n1 = 2'd2;
    end else if (d_d >= 11'(stc_pkg::DAYS_1Y)) begin
      n1 = 2'd1;
    end else begin
      n1 = 2'd0;
    end
  end

  assign d1 = d_d - 11'(n1) * 11'(stc_pkg::DAYS_1Y);

  always_ff @(posedge clk) begin
    if (ene) begin
      year        <= 12'd1601 + 12'(n400_d) * 12'd400 + 12'(n100_d) * 12'd100
                     + 12'(n4_d) * 12'd4 + 12'(n1);
      day_of_year <= 9'(d1) + 9'd1;
      tod         <= t_d;
    end
  end

  assign out_valid = ve;

endmodule

`default_nettype wire

[rtl/core/stc_chk.sv]
// ----------------------------------------------------------------------------
// stc_chk
// Port-level checks for the sample timestamp to calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic        pready
);

  // A stalled output beat stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A rate write starts the divider, so no beat is taken next cycle.
  a_rate_block: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == stc_pkg::REG_RATE
    |=> !s_tready)
    else $error("input taken while sample period is recomputed");

  // Every result lies at or after 1970.
  a_year: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[11:0] >= 12'd1970)
    else $error("year below 1970");

endmodule

bind sample_timestamp_to_calendar stc_chk u_stc_chk (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata,
  .psel, .penable, .pwrite, .paddr, .pready
);

`default_nettype wire

[sim/tb_sample_timestamp_to_calendar.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sample_timestamp_to_calendar
// Self-checking bench for the sample timestamp to calendar converter. A
// directed table of corner beats runs first, then random beats under several
// register settings. Each output beat is compared field by field against a
// calendar predictor written from the converter's specification.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sample_timestamp_to_calendar;

  typedef struct packed {
    logic [15:0] sample_index;
    logic [29:0] start_ns;
    logic [31:0] secs;
  } sample_t;

  typedef struct packed {
    logic [13:0] tenth;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [8:0]  yday;
    logic [11:0] year;
  } cal_t;

  typedef struct {
    sample_t smp;
    logic    has_cal;
    cal_t    cal;
  } row_t;

  localparam int LIMIT = 400000;

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [79:0] s_tdata;
  logic [55:0] m_tdata;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  sample_t   sent_q[$];
  cal_t      cal_q[$];
  row_t      rows[$];
  logic [14:0] rate_reg;
  logic [15:0] base_reg;
  int        errors;
  int        cycles;
  bit        calm;
  bit        hold_on;

  sample_timestamp_to_calendar DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Calendar time of one sample under the current register values.
  function automatic cal_t calendar_of(sample_t s);
    logic [63:0] rate, period, us, fraction, abs_sec, days, sod, d;
    logic [63:0] n400, n100, n4, n1;
    cal_t c;
    rate = (rate_reg == 0) ? 64'd1 : 64'(rate_reg);
    period = 64'd1000000 / rate;
    us = 64'(s.start_ns) / 1000 + 64'(s.sample_index) * period;
    fraction = us % 1000000;
    abs_sec = 64'(base_reg) * 86400 + 64'(s.secs) + us / 1000000;
    days = abs_sec / 86400;
    sod = abs_sec % 86400;
    d = days + 134774;
    n400 = d / 146097;
    d = d % 146097;
    n100 = d / 36524;
    if (n100 == 4) n100 = 3;
    d = d - n100 * 36524;
    n4 = d / 1461;
    d = d % 1461;
    n1 = d / 365;
    if (n1 == 4) n1 = 3;
    d = d - n1 * 365;
    c.year = 12'(1601 + 400 * n400 + 100 * n100 + 4 * n4 + n1);
    c.yday = 9'(d + 1);
    c.hour = 5'(sod / 3600);
    c.minute = 6'((sod / 60) % 60);
    c.second = 6'(sod % 60);
    c.tenth = 14'(fraction / 100);
    return c;
  endfunction

  function automatic bit gap();
    return !calm && ($urandom_range(99) < 7);
  endfunction

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[2] == stc_pkg::REG_BASE) base_reg = value[15:0];
    else rate_reg = value[14:0];
  endtask

  // Drive one input beat and wait for it to be taken; beats follow back to
  // back unless random idle cycles are drawn.
  task automatic send_beat(sample_t s);
    while (gap()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b0, s};
    sent_q.push_back(s);
    do @(posedge clk); while (!s_tready);
  endtask

  // Random beat: mostly legal nanoseconds, sometimes the full 30-bit range.
  function automatic sample_t rand_sample();
    sample_t s;
    s.secs = (($urandom_range(3) == 0) ? $urandom : $urandom_range(200000000));
    s.start_ns = ($urandom_range(9) == 0) ? 30'($urandom) : 30'($urandom_range(999999999));
    s.sample_index = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(255));
    return s;
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sent_q.size() != 0 || cal_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Predict on acceptance so that register writes between phases are honored.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) cal_q.push_back(calendar_of(sent_q.pop_front()));
  end

  // Compare each output beat with the oldest expectation.
  always @(posedge clk) begin
    cal_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = cal_t'(m_tdata[51:0]);
      if (cal_q.size() == 0) begin
        $error("output beat with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        want = cal_q.pop_front();
        if (got.year !== want.year) begin
          $error("year expected %0d got %0d", want.year, got.year); errors++;
        end
        if (got.yday !== want.yday) begin
          $error("day_of_year expected %0d got %0d", want.yday, got.yday); errors++;
        end
        if (got.hour !== want.hour) begin
          $error("hour expected %0d got %0d", want.hour, got.hour); errors++;
        end
        if (got.minute !== want.minute) begin
          $error("minute expected %0d got %0d", want.minute, got.minute); errors++;
        end
        if (got.second !== want.second) begin
          $error("second expected %0d got %0d", want.second, got.second); errors++;
        end
        if (got.tenth !== want.tenth) begin
          $error("tenth_millisecond expected %0d got %0d", want.tenth, got.tenth);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int held;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_on) begin
        m_tready <= 1'b0;
        for (held = 0; held < 200; held++) @(posedge clk);
        hold_on = 1'b0;
      end
      m_tready <= !gap();
    end
  end

  // Cycle limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Directed table rows; expected values typed in only for plain cases.
  task automatic add_row(logic [31:0] secs, logic [29:0] ns, logic [15:0] idx,
                         logic has, logic [11:0] yr, logic [8:0] yd, logic [4:0] hr,
                         logic [5:0] mi, logic [5:0] se, logic [13:0] te);
    row_t r;
    r.smp = '{sample_index: idx, start_ns: ns, secs: secs};
    r.has_cal = has;
    r.cal = '{tenth: te, second: se, minute: mi, hour: hr, yday: yd, year: yr};
    rows.push_back(r);
  endtask

  initial begin
    int i, phase;
    cal_t want;
    logic [2:0] rate_addr, base_addr;
    errors = 0; calm = 1'b0; hold_on = 1'b0;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rate_reg = stc_pkg::RATE_RESET; base_reg = stc_pkg::BASE_RESET;
    rate_addr = {stc_pkg::REG_RATE, 2'b00};
    base_addr = {stc_pkg::REG_BASE, 2'b00};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: base is 2018-01-01, period 10 ms.
    add_row(32'd0, 30'd0, 16'd0, 1, 12'd2018, 9'd1, 5'd0, 6'd0, 6'd0, 14'd0);
    add_row(32'd86399, 30'd999999999, 16'd0, 1, 12'd2018, 9'd1, 5'd23, 6'd59, 6'd59,
            14'd9999);
    add_row(32'd0, 30'd0, 16'd100, 1, 12'd2018, 9'd1, 5'd0, 6'd0, 6'd1, 14'd0);
    add_row(32'd0, 30'h3FFFFFFF, 16'd0, 0, '0, '0, '0, '0, '0, '0);
    add_row(32'hFFFFFFFF, 30'h3FFFFFFF, 16'hFFFF, 0, '0, '0, '0, '0, '0, '0);
    add_row(32'd31535999, 30'd0, 16'd0, 1, 12'd2018, 9'd365, 5'd23, 6'd59, 6'd59,
            14'd0);
    add_row(32'd68083200, 30'd0, 16'd0, 0, '0, '0, '0, '0, '0, '0);
    add_row(32'd63071999, 30'd0, 16'd0, 0, '0, '0, '0, '0, '0, '0);
    add_row(32'd1234567, 30'd123456789, 16'd777, 0, '0, '0, '0, '0, '0, '0);
    add_row(32'hAAAAAAAA, 30'h15555555, 16'h5555, 0, '0, '0, '0, '0, '0, '0);
    add_row(32'h55555555, 30'h2AAAAAAA, 16'hAAAA, 0, '0, '0, '0, '0, '0, '0);
    calm = 1'b1;
    for (i = 0; i < rows.size(); i++) begin
      send_beat(rows[i].smp);
      if (rows[i].has_cal) begin
        want = calendar_of(rows[i].smp);
        if (want !== rows[i].cal) begin
          $error("table row %0d: expected %h predicted %h", i, rows[i].cal, want);
          errors++;
        end
      end
    end
    drain();

    // Settings, extremes included: zero rate, top rate, base 0 and top base.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(rate_addr, 32'd0);
          write_reg(base_addr, 32'd0);
        end
        1: begin
          write_reg(rate_addr, 32'd32767);
          write_reg(base_addr, 32'd65535);
        end
        2: begin
          write_reg(rate_addr, 32'd1);
          write_reg(base_addr, 32'h5555);
        end
        3: begin
          write_reg(rate_addr, 32'h2AAA);
          write_reg(base_addr, 32'hAAAA);
        end
        4: begin
          write_reg(rate_addr, 32'h5555);
          write_reg(base_addr, 32'd17532);
        end
        default: begin
          write_reg(rate_addr, $urandom_range(32767));
          write_reg(base_addr, $urandom_range(65535));
        end
      endcase
      calm = (phase == 2);
      if (phase == 3) hold_on = 1'b1;
      for (i = 0; i < 190; i++) send_beat(rand_sample());
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/core/stc_pkg.sv
rtl/core/stc_cfg.sv
rtl/core/stc_ofs.sv
rtl/core/stc_tod.sv
rtl/core/stc_civ.sv
rtl/core/sample_timestamp_to_calendar.sv
rtl/core/stc_chk.sv
sim/tb_sample_timestamp_to_calendar.sv
